// ===== rtl/core/b58d_pkg.sv =====
// ----------------------------------------------------------------------------
// b58d_pkg
// Shared types, constants and the alphabet lookup for the base58 decoder.
// ----------------------------------------------------------------------------
package b58d_pkg;

  localparam int MaxBytes = 64;
  localparam int AddrW    = $clog2(MaxBytes);
  localparam int LenW     = $clog2(MaxBytes + 1);
  localparam int Radix    = 58;

  localparam logic [7:0] ZeroChar = 8'h31;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusBadSymbol = 2'd1,
    StatusOverflow  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } b58_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    status_e    status;
    logic       final_byte;
  } b58_out_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b58_digit_t;

  // Bitcoin alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z
  function automatic b58_digit_t b58_digit(input logic [7:0] ch);
    b58_digit_t d;
    logic [7:0] off;
    d   = '0;
    off = '0;
    if (ch >= 8'h31 && ch <= 8'h39) begin
      off = ch - 8'h31;
      d.valid = 1'b1;
    end else if (ch >= 8'h41 && ch <= 8'h48) begin
      off = ch - 8'h41 + 8'd9;
      d.valid = 1'b1;
    end else if (ch >= 8'h4A && ch <= 8'h4E) begin
      off = ch - 8'h4A + 8'd17;
      d.valid = 1'b1;
    end else if (ch >= 8'h50 && ch <= 8'h5A) begin
      off = ch - 8'h50 + 8'd22;
      d.valid = 1'b1;
    end else if (ch >= 8'h61 && ch <= 8'h6B) begin
      off = ch - 8'h61 + 8'd33;
      d.valid = 1'b1;
    end else if (ch >= 8'h6D && ch <= 8'h7A) begin
      off = ch - 8'h6D + 8'd44;
      d.valid = 1'b1;
    end
    d.value = off[5:0];
    return d;
  endfunction

endpackage

// ===== rtl/core/b58d_ram.sv =====
// ----------------------------------------------------------------------------
// b58d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module b58d_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/base58_decoder.sv =====
// ----------------------------------------------------------------------------
// base58_decoder
// Base58 (Bitcoin alphabet) text to bytes, one character per input word.
// ----------------------------------------------------------------------------
// Input channel: one character per word, final_symbol set on the last one.
// Output channel: decoded bytes, most significant first, final_byte on the
// last; an invalid character or an oversized result gives a single error
// word (status set, data zero) instead.
// Each character runs through one shared 8x6 multiply-add unit that walks
// the little-endian magnitude RAM one byte per cycle; in_stall_o is high
// while a character is in progress.
// On the final character the bytes are emitted from a single output
// register: zero bytes directly, magnitude bytes after a RAM read, and
// out_stall_i holds a waiting byte in the register. A new character is
// taken once the last byte has been loaded, even if that byte still waits.
// Reset (rst_ni low) clears the control state and drops any pending output;
// the magnitude RAM needs no clearing as only written bytes are read.
// ----------------------------------------------------------------------------
module base58_decoder
  import b58d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  b58_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output b58_out_t out_word_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMac,
    StExt,
    StFinish,
    StEmit,
    StEmitLd
  } state_e;

  state_e           state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  zp_q, zp_d;
  logic             in_prefix_q, in_prefix_d;
  logic             bad_q, bad_d;
  logic             ovf_q, ovf_d;
  logic             last_q, last_d;
  logic [5:0]       carry_q, carry_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [LenW-1:0]  zcnt_q, zcnt_d;
  logic [LenW-1:0]  mcnt_q, mcnt_d;
  logic             out_valid_q, out_valid_d;
  b58_out_t         out_word_q, out_word_d;

  logic             ram_wr_en, ram_rd_en;
  logic [AddrW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]       ram_wr_data, ram_rd_data;

  b58_digit_t       dig;
  logic             prefix_ovf;
  logic             clr;
  logic             out_free;
  logic [13:0]      mac_sum;
  logic [LenW-1:0]  idx_nx;
  logic [LenW-1:0]  len_nx;
  logic [LenW-1:0]  mcnt_m1;
  logic [LenW:0]    total;

  b58d_ram #(
    .Width (8),
    .Depth (MaxBytes)
  ) u_mag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // shared unit: byte * 58 + carry
  assign mac_sum = 14'(carry_q) + 14'(ram_rd_data) * 14'(Radix);
  assign idx_nx  = LenW'(idx_q) + LenW'(1);
  assign mcnt_m1 = mcnt_q - LenW'(1);
  assign dig     = b58_digit(in_word_i.symbol);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    zp_d        = zp_q;
    in_prefix_d = in_prefix_q;
    bad_d       = bad_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    carry_d     = carry_q;
    idx_d       = idx_q;
    zcnt_d      = zcnt_q;
    mcnt_d      = mcnt_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    prefix_ovf  = 1'b0;
    clr         = 1'b0;
    len_nx      = len_q;
    total       = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          last_d = in_word_i.final_symbol;
          if (bad_q || ovf_q) begin
            state_d = StFinish;
          end else if (!dig.valid) begin
            bad_d   = 1'b1;
            state_d = StFinish;
          end else begin
            if (in_prefix_q && in_word_i.symbol == ZeroChar) begin
              if (zp_q >= LenW'(MaxBytes)) begin
                ovf_d      = 1'b1;
                prefix_ovf = 1'b1;
              end else begin
                zp_d = zp_q + LenW'(1);
              end
            end else begin
              in_prefix_d = 1'b0;
            end
            carry_d = dig.value;
            idx_d   = '0;
            if (prefix_ovf) begin
              state_d = StFinish;
            end else if (len_q != '0) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              state_d     = StMac;
            end else begin
              state_d = StExt;
            end
          end
        end
      end

      StMac: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_q;
        ram_wr_data = mac_sum[7:0];
        carry_d     = mac_sum[13:8];
        if (idx_nx < len_q) begin
          idx_d       = idx_nx[AddrW-1:0];
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_nx[AddrW-1:0];
        end else begin
          state_d = StExt;
        end
      end

      StExt: begin
        // carry is below 256 here, so at most one new byte
        if (carry_q != '0) begin
          if (len_q >= LenW'(MaxBytes)) begin
            ovf_d = 1'b1;
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = len_q[AddrW-1:0];
            ram_wr_data = {2'b00, carry_q};
            len_nx      = len_q + LenW'(1);
          end
        end
        len_d = len_nx;
        total = (LenW+1)'(zp_q) + (LenW+1)'(len_nx);
        if (total > (LenW+1)'(MaxBytes)) begin
          ovf_d = 1'b1;
        end
        state_d = StFinish;
      end

      StFinish: begin
        if (!last_q) begin
          state_d = StIdle;
        end else if (bad_q || ovf_q) begin
          if (out_free) begin
            out_valid_d           = 1'b1;
            out_word_d.data_byte  = '0;
            out_word_d.status     = bad_q ? StatusBadSymbol : StatusOverflow;
            out_word_d.final_byte = 1'b1;
            clr                   = 1'b1;
            state_d               = StIdle;
          end
        end else begin
          zcnt_d  = zp_q;
          mcnt_d  = len_q;
          state_d = StEmit;
        end
      end

      StEmit: begin
        if (zcnt_q != '0) begin
          if (out_free) begin
            out_valid_d           = 1'b1;
            out_word_d.data_byte  = '0;
            out_word_d.status     = StatusOk;
            out_word_d.final_byte = (zcnt_q == LenW'(1)) && (mcnt_q == '0);
            zcnt_d                = zcnt_q - LenW'(1);
            if ((zcnt_q == LenW'(1)) && (mcnt_q == '0)) begin
              clr     = 1'b1;
              state_d = StIdle;
            end
          end
        end else if (mcnt_q != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = mcnt_m1[AddrW-1:0];
          state_d     = StEmitLd;
        end else begin
          clr     = 1'b1;
          state_d = StIdle;
        end
      end

      StEmitLd: begin
        // read data holds until the next read
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_word_d.data_byte  = ram_rd_data;
          out_word_d.status     = StatusOk;
          out_word_d.final_byte = (mcnt_q == LenW'(1));
          mcnt_d                = mcnt_m1;
          if (mcnt_q == LenW'(1)) begin
            clr     = 1'b1;
            state_d = StIdle;
          end else begin
            state_d = StEmit;
          end
        end
      end

      default: state_d = StIdle;
    endcase

    if (clr) begin
      len_d       = '0;
      zp_d        = '0;
      in_prefix_d = 1'b1;
      bad_d       = 1'b0;
      ovf_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      zp_q        <= '0;
      in_prefix_q <= 1'b1;
      bad_q       <= 1'b0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      carry_q     <= '0;
      idx_q       <= '0;
      zcnt_q      <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      zp_q        <= zp_d;
      in_prefix_q <= in_prefix_d;
      bad_q       <= bad_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      carry_q     <= carry_d;
      idx_q       <= idx_d;
      zcnt_q      <= zcnt_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== bench/tb_base58_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_base58_decoder
// Self-checking bench for the base58 decoder. Texts of base58 characters are
// fed one word at a time with random gaps while the output side stalls at
// random. A behavioural decoder in the bench predicts every output byte, and
// each accepted output word is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_base58_decoder;
  import b58d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalItems  = 170;
  localparam int LongIdle    = 40;
  localparam int DrainCycles = 4 * (MaxBytes + 3);

  typedef enum int {
    LongZeros,
    LongZeroOverflow,
    LongFullWidth,
    LongTotalOverflow,
    LongMagOverflow,
    LongDone
  } long_text_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  b58_in_t  in_word_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  b58_out_t out_word_o;

  base58_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  string alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  b58_in_t  pending_chars[$];
  b58_out_t expected_bytes[$];

  // decoder state mirrored in the bench
  logic [7:0] mag_bytes[MaxBytes];
  int         mag_len;
  int         zero_run;
  bit         in_zero_run = 1'b1;
  bit         saw_bad;
  bit         saw_overflow;

  int  errors;
  int  cycle_count;
  int  run_limit;
  int  send_gap;
  int  stall_left;
  bit  calm_tx;
  bit  calm_rx;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit b58_value(input logic [7:0] ch, output int unsigned d);
    int k;
    d = 0;
    for (k = 0; k < 58; k++) begin
      if (alphabet[k] == ch) begin
        d = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] bad_char();
    int unsigned d;
    int unsigned tmp;
    logic [7:0]  ch;
    do begin
      tmp = $urandom_range(0, 255);
      ch  = tmp[7:0];
    end while (b58_value(ch, d));
    return ch;
  endfunction

  // mostly short gaps, now and then a long one, none at all in calm spells
  function automatic int idle_len(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, LongIdle);
  endfunction

  task automatic mac_digit(input int unsigned digit);
    int unsigned carry;
    int          k;
    carry = digit;
    for (k = 0; k < mag_len; k++) begin
      carry        = carry + mag_bytes[k] * 58;
      mag_bytes[k] = carry[7:0];
      carry        = carry >> 8;
    end
    while (carry > 0) begin
      if (mag_len >= MaxBytes) begin
        saw_overflow = 1'b1;
        return;
      end
      mag_bytes[mag_len] = carry[7:0];
      mag_len++;
      carry = carry >> 8;
    end
  endtask

  task automatic decode_symbol(input b58_in_t w);
    int unsigned d;
    int          total;
    int          k;
    b58_out_t    r;
    if (!saw_bad && !saw_overflow) begin
      if (!b58_value(w.symbol, d)) begin
        saw_bad = 1'b1;
      end else begin
        if (in_zero_run && w.symbol == ZeroChar) begin
          if (zero_run >= MaxBytes) saw_overflow = 1'b1;
          else zero_run++;
        end else begin
          in_zero_run = 1'b0;
        end
        if (!saw_overflow) mac_digit(d);
        if (zero_run + mag_len > MaxBytes) saw_overflow = 1'b1;
      end
    end
    if (w.final_symbol) begin
      if (saw_bad || saw_overflow) begin
        r.data_byte  = 8'h00;
        r.status     = saw_bad ? StatusBadSymbol : StatusOverflow;
        r.final_byte = 1'b1;
        expected_bytes = {expected_bytes, r};
      end else begin
        total = zero_run + mag_len;
        for (k = 0; k < zero_run; k++) begin
          r.data_byte  = 8'h00;
          r.status     = StatusOk;
          r.final_byte = (k + 1 == total);
          expected_bytes = {expected_bytes, r};
        end
        for (k = mag_len; k > 0; k--) begin
          r.data_byte  = mag_bytes[k - 1];
          r.status     = StatusOk;
          r.final_byte = (k == 1);
          expected_bytes = {expected_bytes, r};
        end
      end
      mag_len      = 0;
      zero_run     = 0;
      in_zero_run  = 1'b1;
      saw_bad      = 1'b0;
      saw_overflow = 1'b0;
    end
  endtask

  task automatic push_char(input logic [7:0] ch, input bit last);
    b58_in_t w;
    w.symbol       = ch;
    w.final_symbol = last;
    pending_chars  = {pending_chars, w};
  endtask

  task automatic push_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // prefix of '1's, then a body whose first char comes from lead_lo upward
  task automatic push_text(input int prefix, input int body, input int lead_lo,
                           input int bad_at);
    int         n;
    int         i;
    logic [7:0] ch;
    n = prefix + body;
    for (i = 0; i < n; i++) begin
      if (i == bad_at) ch = bad_char();
      else if (i < prefix) ch = ZeroChar;
      else if (i == prefix) ch = alphabet[$urandom_range(lead_lo, 57)];
      else ch = alphabet[$urandom_range(0, 57)];
      push_char(ch, i == n - 1);
    end
  endtask

  task automatic push_long(input long_text_e kind);
    case (kind)
      LongZeros:         push_text(MaxBytes, 0, 1, -1);
      LongZeroOverflow:  push_text(MaxBytes + 1, $urandom_range(0, 2), 1, -1);
      // 87 digits led by 2 or more: exactly a full store
      LongFullWidth:     push_text(0, 87, 2, -1);
      LongTotalOverflow: push_text($urandom_range(1, 3), 87, 2, -1);
      // on half the runs a bad char late in the text, after the carry has already spilled
      LongMagOverflow:   push_text(0, 92, 1, $urandom_range(0, 1) ? 91 : -1);
      default: ;
    endcase
  endtask

  task automatic push_random_text();
    int unsigned kind;
    int          n;
    int          i;
    int          prefix;
    int          body;
    int unsigned tmp;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
        tmp = $urandom_range(0, 255);
        push_char(tmp[7:0], i == n - 1);
      end
    end else begin
      prefix = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 10) : $urandom_range(0, 2);
      body   = ($urandom_range(0, 6) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      if (prefix + body == 0) body = 1;
      push_text(prefix, body, 1, (kind < 30) ? $urandom_range(0, prefix + body - 1) : -1);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) decode_symbol(in_word_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          in_word_i  <= pending_chars.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= idle_len(calm_tx);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i) begin
    b58_out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word: data %02h status %0d final %b", $time,
                 out_word_o.data_byte, out_word_o.status, out_word_o.final_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_word_o.data_byte !== want.data_byte || out_word_o.status !== want.status ||
            out_word_o.final_byte !== want.final_byte) begin
          $display("%0t: data/status/final expected %02h/%0d/%b, got %02h/%0d/%b",
                   $time, want.data_byte, want.status, want.final_byte,
                   out_word_o.data_byte, out_word_o.status, out_word_o.final_byte);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_left  <= idle_len(calm_rx);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) begin
      calm_tx <= ($urandom_range(0, 3) == 0);
      calm_rx <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    wait (run_limit != 0 && cycle_count > run_limit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int         split_at;
    long_text_e long_kind;
    // one long text per run, dropped in somewhere among the random ones
    long_kind = long_text_e'($urandom_range(0, int'(LongDone) - 1));
    split_at  = $urandom_range(0, TotalItems / 2);

    // directed texts: single chars, prefixes, alphabet edges and holes
    push_string("1");
    push_string("z");
    push_string("11z");
    push_string("2g");
    push_string("z1");
    push_string("0");
    push_char(8'hFF, 1'b0);
    push_string("2");
    push_char(8'h00, 1'b1);
    push_string("2O3");
    push_string("9AHJNPZakmz");

    while (pending_chars.size() < TotalItems) begin
      if (long_kind != LongDone && pending_chars.size() >= split_at) begin
        push_long(long_kind);
        long_kind = LongDone;
      end
      push_random_text();
    end
    if (long_kind != LongDone) push_long(long_kind);

    run_limit = 10000 + 4 * pending_chars.size() *
                (MaxBytes * (LongIdle + 2) + MaxBytes + 3 + LongIdle);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
